/* rtl/fvn_pkg.sv */
// Shared constants, register codes and lattice helpers for the fractal value noise block.
`default_nettype none

package fvn_pkg;

    // Width of a coordinate times the base frequency (32 signed by 24 unsigned).
    localparam int PROD_W = 57;
    // Octave weights are unsigned Q1.16, never above one.
    localparam int AMP_W = 17;
    localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;

    localparam logic [31:0] LAT_ZMUL = 32'd57;
    localparam logic [31:0] HASH_C1  = 32'd15731;
    localparam logic [31:0] HASH_C2  = 32'd789221;
    localparam logic [31:0] HASH_C3  = 32'd1376312589;

    typedef enum logic [2:0] {
        REG_BASE_FREQ  = 3'd0,
        REG_PERSIST    = 3'd1,
        REG_HEIGHT_GAIN = 3'd2,
        REG_OCT_COUNT  = 3'd3,
        REG_SEED       = 3'd4
    } t_reg_idx;

    // Hash input offset of lattice point k (x offset k%4-1, z offset k/4-1).
    function automatic logic [31:0] lat_ofs(input int k);
        int dx;
        int dz;
        dx = (k % 4) - 1;
        dz = (k / 4) - 1;
        return 32'(dx + 57 * dz);
    endfunction

endpackage

`default_nettype wire

/* rtl/fvn_in_if.sv */
// Sample point channel: one word carries an x and z coordinate.
`default_nettype none

interface fvn_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;

    modport source (output valid, output x_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

`default_nettype wire

/* rtl/fvn_out_if.sv */
// Height channel: one word carries one height sample.
`default_nettype none

interface fvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height_value;

    modport source (output valid, output height_value, input ready);
    modport sink   (input valid, input height_value, output ready);
endinterface

`default_nettype wire

/* rtl/fvn_octave.sv */
// One octave lane: lattice hash of a 4x4 neighborhood, corner smoothing, bilinear blend.
`default_nettype none

module fvn_octave
    import fvn_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int OCT = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic signed [PROD_W-1:0]   i_px,
    input  wire logic signed [PROD_W-1:0]   i_pz,
    input  wire logic [31:0]                i_seed,
    output logic signed [FRAC_BITS+5:0]     o_val
);
    localparam int F  = FRAC_BITS;
    localparam int GW = F + 2;
    localparam int CW = F + 6;
    localparam int DW = CW + 1;
    localparam int SW = F + 1;
    localparam int PW = DW + F + 1;
    localparam logic signed [GW-1:0] G_ONE = GW'(1) << F;

    logic [63:0] w_ux, w_uz;
    logic [31:0] r_xi, r_zi, r_base;
    logic [F-1:0] r_fx[9];
    logic [F-1:0] r_fz[11];
    logic [31:0] r_m[16], r_m4[16], r_m5[16], r_sq[16], r_t1[16], r_t2[16];
    logic signed [GW-1:0] r_g[16];
    logic signed [CW-1:0] w_c[4], r_c[4];
    logic signed [DW-1:0] r_d0, r_d1, r_dr;
    logic signed [CW-1:0] r_a0, r_a1, r_r0, r_r1, r_b, r_val;
    logic signed [PW-1:0] w_p0, w_p1, w_p2, w_s0, w_s1, w_s2;

    // Scale by 2^OCT modulo 2^64, split into lattice integer and fraction.
    always_comb begin
        w_ux = {{(64-PROD_W){i_px[PROD_W-1]}}, i_px} << OCT;
        w_uz = {{(64-PROD_W){i_pz[PROD_W-1]}}, i_pz} << OCT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xi     <= w_ux[63:32] + i_seed;
            r_zi     <= w_uz[63:32] + i_seed;
            r_fx[0]  <= w_ux[31:32-F];
            r_fz[0]  <= w_uz[31:32-F];
            r_base   <= r_xi + r_zi * LAT_ZMUL;
            for (int i = 1; i < 9; i++) r_fx[i] <= r_fx[i-1];
            for (int i = 1; i < 11; i++) r_fz[i] <= r_fz[i-1];
        end
    end

    for (genvar k = 0; k < 16; k++) begin : g_hash
        logic [31:0] w_n;
        assign w_n = r_base + lat_ofs(k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]  <= (w_n << 13) ^ w_n;
                r_sq[k] <= r_m[k] * r_m[k];
                r_m4[k] <= r_m[k];
                r_t1[k] <= r_sq[k] * HASH_C1 + HASH_C2;
                r_m5[k] <= r_m4[k];
                r_t2[k] <= r_m5[k] * r_t1[k] + HASH_C3;
                r_g[k]  <= G_ONE - signed'(GW'(SW'(r_t2[k][30:0] >> (30 - F))));
            end
        end
    end

    // Smooth each cell corner: diagonals, twice the edges, four times the center.
    for (genvar q = 0; q < 4; q++) begin : g_corner
        localparam int CX = 1 + (q % 2);
        localparam int CZ = 1 + (q / 2);
        logic signed [CW-1:0] w_diag, w_edge;
        always_comb begin
            w_diag = CW'(r_g[(CZ-1)*4 + CX-1]) + CW'(r_g[(CZ-1)*4 + CX+1])
                   + CW'(r_g[(CZ+1)*4 + CX-1]) + CW'(r_g[(CZ+1)*4 + CX+1]);
            w_edge = CW'(r_g[CZ*4 + CX-1]) + CW'(r_g[CZ*4 + CX+1])
                   + CW'(r_g[(CZ-1)*4 + CX]) + CW'(r_g[(CZ+1)*4 + CX]);
            w_c[q] = w_diag + (w_edge <<< 1) + (CW'(r_g[CZ*4 + CX]) <<< 2);
        end
    end

    always_comb begin
        w_p0 = r_d0 * signed'({1'b0, r_fx[8]});
        w_p1 = r_d1 * signed'({1'b0, r_fx[8]});
        w_s0 = (w_p0 >>> F) + PW'(r_a0);
        w_s1 = (w_p1 >>> F) + PW'(r_a1);
        w_p2 = r_dr * signed'({1'b0, r_fz[10]});
        w_s2 = (w_p2 >>> F) + PW'(r_b);
    end

    // Blend as a + floor((b - a) * w), which equals the weighted form exactly.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) r_c[i] <= w_c[i];
            r_d0  <= DW'(r_c[1]) - DW'(r_c[0]);
            r_d1  <= DW'(r_c[3]) - DW'(r_c[2]);
            r_a0  <= r_c[0];
            r_a1  <= r_c[2];
            r_r0  <= w_s0[CW-1:0];
            r_r1  <= w_s1[CW-1:0];
            r_dr  <= DW'(r_r1) - DW'(r_r0);
            r_b   <= r_r0;
            r_val <= w_s2[CW-1:0];
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

/* rtl/fvn_div.sv */
// Pipelined floor division of a signed sum by a positive weight, one quotient bit per stage.
`default_nettype none

module fvn_div
    import fvn_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 20,
    parameter int QB = 21
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic signed [NW-1:0]   i_num,
    input  wire logic [DW-1:0]          i_den,
    output logic                        o_vld,
    output logic signed [QB:0]          o_quo
);
    localparam int RW = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam int QW = QB + 1;

    logic [RW-1:0] w_ns, w_mag;
    logic [RW-1:0] r_rem[QB+1];
    logic [QB-1:0] r_q[QB+1];
    logic [DW-1:0] r_d[QB];
    logic          r_neg[QB+1];
    logic          r_v[QB+2];
    logic signed [QW-1:0] r_quo;

    // Negative dividend: divide d - 1 - v so the truncated quotient is the ceiling.
    always_comb begin
        w_ns  = RW'(i_num);
        w_mag = i_num[NW-1] ? (RW'(i_den) - RW'(1) - w_ns) : w_ns;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_mag;
            r_q[0]   <= '0;
            r_d[0]   <= i_den;
            r_neg[0] <= i_num[NW-1];
            r_quo    <= r_neg[QB] ? -signed'(QW'(r_q[QB])) : signed'(QW'(r_q[QB]));
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        localparam int B = QB - 1 - k;
        logic [RW-1:0] w_dsh;
        assign w_dsh = RW'(r_d[k]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= w_dsh) begin
                    r_rem[k+1] <= r_rem[k] - w_dsh;
                    r_q[k+1]   <= r_q[k] | (QB'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
                r_neg[k+1] <= r_neg[k];
            end
        end
        if (k + 1 < QB) begin : g_dpass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k+1] <= r_d[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QB + 2; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
            for (int i = 1; i < QB + 2; i++) r_v[i] <= r_v[i-1];
        end
    end

    assign o_vld = r_v[QB+1];
    assign o_quo = r_quo;

endmodule

`default_nettype wire

/* rtl/fractal_value_noise_height_top.sv */
// Top level of the fractal value noise height generator.
// Throughput: one sample per cycle unless the output buffer is full and the receiver is not ready;
// all octave lanes run side by side, weights accumulate over MAX_OCTAVES stages and the
// normalizing divide resolves one quotient bit per stage.
// A two-word output buffer keeps the input open while a result waits.
// Synchronous active-low reset clears valid bits and loads the register defaults.
`default_nettype none

module fractal_value_noise_height_top
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fvn_in_if.sink           i_sample,
    fvn_out_if.source        o_height,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int F  = FRACTION_BITS;
    localparam int CW = F + 6;
    localparam int MW = CW + AMP_W + 1;
    localparam int VW = MW + $clog2(MAX_OCTAVES) + 1;
    localparam int WW = AMP_W + $clog2(MAX_OCTAVES);
    localparam int PW = CW + 32;

    logic [23:0] r_base_freq;
    logic [16:0] r_pers;
    logic [30:0] r_hgain;
    logic [3:0]  r_oct_cnt;
    logic [31:0] r_seed;

    logic en, pop, push;
    logic [1:0] r_cnt;
    logic signed [31:0] r_out0, r_out1;

    logic signed [PROD_W-1:0] r_px, r_pz;
    logic r_vf[13];
    logic signed [CW-1:0] w_val[MAX_OCTAVES];

    logic [4:0]       w_cnt;
    logic [AMP_W-1:0] w_pers;
    logic signed [VW-1:0] r_vsum[MAX_OCTAVES];
    logic [WW-1:0]        r_wsum[MAX_OCTAVES];
    logic [AMP_W-1:0]     r_amp[MAX_OCTAVES];
    logic signed [CW-1:0] r_vals[MAX_OCTAVES][MAX_OCTAVES];
    logic                 r_av[MAX_OCTAVES];

    logic                 w_dv;
    logic signed [CW-1:0] w_norm;
    logic signed [PW-1:0] r_p, w_sh;
    logic                 r_mv, r_hv;
    logic signed [31:0]   r_h, w_sat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq <= 24'd65536;
            r_pers      <= 17'd32768;
            r_hgain     <= 31'd65536;
            r_oct_cnt   <= 4'd1;
            r_seed      <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_BASE_FREQ:   r_base_freq <= i_cfg_data[23:0];
                REG_PERSIST:     r_pers      <= i_cfg_data[16:0];
                REG_HEIGHT_GAIN: r_hgain     <= i_cfg_data[30:0];
                REG_OCT_COUNT:   r_oct_cnt   <= i_cfg_data[3:0];
                REG_SEED:        r_seed      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output buffer and global advance
    assign pop  = (r_cnt != 2'd0) && o_height.ready;
    assign en   = (r_cnt != 2'd2) || pop;
    assign push = en && r_hv;

    assign i_sample.ready      = en;
    assign o_height.valid      = (r_cnt != 2'd0);
    assign o_height.height_value = r_out0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out0 <= (r_cnt == 2'd2) ? r_out1 : r_h;
        end else if (push && r_cnt == 2'd0) begin
            r_out0 <= r_h;
        end
        if (push && ((r_cnt == 2'd1 && !pop) || (r_cnt == 2'd2 && pop))) begin
            r_out1 <= r_h;
        end
    end

    // Scale both coordinates by the base frequency once; lanes apply the octave shift.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= i_sample.x_coord * signed'({1'b0, r_base_freq});
            r_pz <= i_sample.z_coord * signed'({1'b0, r_base_freq});
        end
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
        fvn_octave #(
            .FRAC_BITS (F),
            .OCT       (o)
        ) u_octave (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_px   (r_px),
            .i_pz   (r_pz),
            .i_seed (r_seed),
            .o_val  (w_val[o])
        );
    end

    always_comb begin
        if (r_oct_cnt == 4'd0) begin
            w_cnt = 5'd1;
        end else if (5'(r_oct_cnt) > 5'(MAX_OCTAVES)) begin
            w_cnt = 5'(MAX_OCTAVES);
        end else begin
            w_cnt = 5'(r_oct_cnt);
        end
        w_pers = (r_pers > AMP_ONE) ? AMP_ONE : r_pers;
    end

    // Weighted octave sum, one octave per stage.
    for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
        logic signed [VW-1:0] w_vs;
        logic [WW-1:0]        w_ws;
        logic [AMP_W-1:0]     w_amp;
        logic signed [CW-1:0] w_vin[MAX_OCTAVES];
        logic signed [MW-1:0] w_prod;
        logic [2*AMP_W-1:0]   w_anext;

        if (j == 0) begin : g_first
            always_comb begin
                w_vs  = '0;
                w_ws  = '0;
                w_amp = AMP_ONE;
                for (int i = 0; i < MAX_OCTAVES; i++) w_vin[i] = w_val[i];
            end
        end else begin : g_next
            always_comb begin
                w_vs  = r_vsum[j-1];
                w_ws  = r_wsum[j-1];
                w_amp = r_amp[j-1];
                for (int i = 0; i < MAX_OCTAVES; i++) w_vin[i] = r_vals[j-1][i];
            end
        end

        always_comb begin
            w_prod  = w_vin[j] * signed'({1'b0, w_amp});
            w_anext = w_amp * w_pers;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (5'(j) < w_cnt) begin
                    r_vsum[j] <= w_vs + VW'(w_prod);
                    r_wsum[j] <= w_ws + WW'(w_amp);
                end else begin
                    r_vsum[j] <= w_vs;
                    r_wsum[j] <= w_ws;
                end
                r_amp[j] <= w_anext[32:16];
                for (int i = 0; i < MAX_OCTAVES; i++) r_vals[j][i] <= w_vin[i];
            end
        end
    end

    fvn_div #(
        .NW (VW),
        .DW (WW),
        .QB (CW - 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_av[MAX_OCTAVES-1]),
        .i_num   (r_vsum[MAX_OCTAVES-1]),
        .i_den   (r_wsum[MAX_OCTAVES-1]),
        .o_vld   (w_dv),
        .o_quo   (w_norm)
    );

    // Apply gain, drop the extra fraction bits and clamp to 32 bits.
    always_comb begin
        w_sh = r_p >>> (F + 4);
        if ((&w_sh[PW-1:31]) || !(|w_sh[PW-1:31])) begin
            w_sat = w_sh[31:0];
        end else if (w_sh[PW-1]) begin
            w_sat = {1'b1, 31'd0};
        end else begin
            w_sat = {1'b0, {31{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= w_norm * signed'({1'b0, r_hgain});
            r_h <= w_sat;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 13; i++) r_vf[i] <= 1'b0;
            for (int i = 0; i < MAX_OCTAVES; i++) r_av[i] <= 1'b0;
            r_mv <= 1'b0;
            r_hv <= 1'b0;
        end else if (en) begin
            r_vf[0] <= i_sample.valid;
            for (int i = 1; i < 13; i++) r_vf[i] <= r_vf[i-1];
            r_av[0] <= r_vf[12];
            for (int i = 1; i < MAX_OCTAVES; i++) r_av[i] <= r_av[i-1];
            r_mv <= w_dv;
            r_hv <= r_mv;
        end
    end

endmodule

`default_nettype wire

/* sim/tb_fractal_value_noise_height_top.sv */
// Testbench for the fractal value noise height block: directed and random points against a local predictor.
`default_nettype none

class height_board;
    int                 mismatches;
    int                 checked;
    logic signed [31:0] pending[$];

    function new();
        mismatches = 0;
        checked = 0;
    endfunction

    function void note_point(logic signed [31:0] h);
        pending.push_back(h);
    endfunction

    // Returns 0 when the word matches the oldest prediction.
    function int check_height(logic signed [31:0] got, output logic signed [31:0] want);
        want = 'x;
        if (pending.size() == 0) begin
            return 2;
        end
        want = pending.pop_front();
        checked++;
        return (got === want) ? 0 : 1;
    endfunction
endclass

module tb_fractal_value_noise_height_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fvn_pkg::*;

    localparam int OCT_MAX = 8;
    localparam int FB = 16;
    localparam int LATENCY = FB + OCT_MAX + 23;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    fvn_in_if  sample_ch();
    fvn_out_if height_ch();

    fractal_value_noise_height_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample(sample_ch.sink), .o_height(height_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    height_board board;
    int  mismatch_count;
    int  sent_points;
    bit  idle_sink;
    int  sink_hold;

    logic [23:0] cur_freq;
    logic [16:0] cur_pers;
    logic [30:0] cur_gain;
    logic [3:0]  cur_octaves;
    logic [31:0] cur_seed;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] div_floor(logic signed [63:0] v,
                                                      logic signed [63:0] d);
        if (v >= 0) return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic logic signed [63:0] hash_lattice(logic [31:0] xi, logic [31:0] zi);
        logic [31:0] n;
        logic [31:0] t;
        n = xi + zi * 32'd57;
        n = (n << 13) ^ n;
        t = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
        t = t & 32'h7fffffff;
        return (64'sd1 <<< FB) - 64'(t >> (30 - FB));
    endfunction

    function automatic logic signed [63:0] mix(logic signed [63:0] a, logic signed [63:0] b,
                                               logic signed [63:0] w);
        return shr_floor(a * ((64'sd1 <<< FB) - w) + b * w, FB);
    endfunction

    function automatic void lattice_pos(logic signed [31:0] c, int oct,
                                        output logic [31:0] ip,
                                        output logic signed [63:0] fp);
        logic signed [63:0] prod;
        logic [63:0]        u;
        prod = 64'(c) * $signed({40'd0, cur_freq});
        u = 64'(prod) << oct;
        ip = u[63:32] + cur_seed;
        fp = 64'(u[31:32-FB]);
    endfunction

    function automatic logic signed [63:0] octave_height(logic signed [31:0] x,
                                                         logic signed [31:0] z, int oct);
        logic [31:0]        xi;
        logic [31:0]        zi;
        logic signed [63:0] fx;
        logic signed [63:0] fz;
        logic signed [63:0] g[4][4];
        logic signed [63:0] c[2][2];
        lattice_pos(x, oct, xi, fx);
        lattice_pos(z, oct, zi, fz);
        for (int dz = 0; dz < 4; dz++)
            for (int dx = 0; dx < 4; dx++)
                g[dz][dx] = hash_lattice(xi + 32'(dx) - 32'd1, zi + 32'(dz) - 32'd1);
        for (int cz = 1; cz <= 2; cz++)
            for (int cx = 1; cx <= 2; cx++)
                c[cz-1][cx-1] = g[cz-1][cx-1] + g[cz-1][cx+1] + g[cz+1][cx-1]
                    + g[cz+1][cx+1]
                    + 2 * (g[cz][cx-1] + g[cz][cx+1] + g[cz-1][cx] + g[cz+1][cx])
                    + 4 * g[cz][cx];
        return mix(mix(c[0][0], c[0][1], fx), mix(c[1][0], c[1][1], fx), fz);
    endfunction

    function automatic logic signed [31:0] predict_height(logic signed [31:0] x,
                                                          logic signed [31:0] z);
        int                 count;
        logic signed [63:0] pers;
        logic signed [63:0] amp;
        logic signed [63:0] wsum;
        logic signed [63:0] vsum;
        logic signed [63:0] h;
        count = cur_octaves;
        if (count < 1) count = 1;
        if (count > OCT_MAX) count = OCT_MAX;
        pers = (cur_pers > 17'd65536) ? 64'sd65536 : 64'(cur_pers);
        amp = 64'sd65536;
        wsum = 0;
        vsum = 0;
        for (int i = 0; i < count; i++) begin
            wsum += amp;
            vsum += octave_height(x, z, i) * amp;
            amp = (amp * pers) >>> 16;
        end
        h = shr_floor(div_floor(vsum, wsum) * 64'(cur_gain), FB + 4);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[31:0];
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_BASE_FREQ:   cur_freq = data[23:0];
            REG_PERSIST:     cur_pers = data[16:0];
            REG_HEIGHT_GAIN: cur_gain = data[30:0];
            REG_OCT_COUNT:   cur_octaves = data[3:0];
            REG_SEED:        cur_seed = data;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] z,
                              input bit may_idle);
        if (may_idle)
            while ($urandom_range(99) < 32) begin
                sample_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        sample_ch.valid <= 1'b1;
        sample_ch.x_coord <= x;
        sample_ch.z_coord <= z;
        do @(posedge i_clk); while (!sample_ch.ready);
        board.note_point(predict_height(x, z));
        sent_points++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
            2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    task automatic random_points(input int n, input bit may_idle);
        for (int k = 0; k < n; k++) send_point(rand_coord(), rand_coord(), may_idle);
        sample_ch.valid <= 1'b0;
    endtask

    // Receiver: random stalls, with a no-stall window and one long hold-off.
    always @(posedge i_clk) begin
        logic signed [31:0] want;
        int                 r;
        if (i_rst_n && height_ch.valid && height_ch.ready) begin
            r = board.check_height(height_ch.height_value, want);
            if (r == 2) report_mismatch($sformatf("unexpected height %0d",
                                                  height_ch.height_value));
            else if (r == 1) report_mismatch($sformatf("height got %0d want %0d",
                                                       height_ch.height_value, want));
        end
        if (sink_hold > 0) begin
            sink_hold--;
            height_ch.ready <= 1'b0;
        end else begin
            height_ch.ready <= idle_sink ? ($urandom_range(99) >= 32) : 1'b1;
        end
    end

    initial begin
        logic [31:0] edge_vals[6];
        board = new();
        mismatch_count = 0;
        sent_points = 0;
        idle_sink = 1'b1;
        sink_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.x_coord = '0;
        sample_ch.z_coord = '0;
        height_ch.ready = 1'b0;
        cur_freq = 24'd65536;
        cur_pers = 17'd32768;
        cur_gain = 31'd65536;
        cur_octaves = 4'd1;
        cur_seed = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: coordinate extremes at reset settings.
        edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000,
                      32'h0000ffff};
        foreach (edge_vals[a]) begin
            send_point(edge_vals[a], edge_vals[(a + 2) % 6], 1'b0);
            send_point(edge_vals[(a + 3) % 6], edge_vals[a], 1'b0);
        end
        sample_ch.valid <= 1'b0;
        drain_results();

        // Zero octaves and zero frequency, then oversized counts and persistence, then zero persistence and gain.
        write_reg(REG_OCT_COUNT, 32'd0);
        write_reg(REG_BASE_FREQ, 32'd0);
        write_reg(REG_SEED, 32'h80000000);
        send_point(32'h12345678, 32'hdeadbeef, 1'b0);
        sample_ch.valid <= 1'b0;
        drain_results();
        write_reg(REG_OCT_COUNT, 32'd15);
        write_reg(REG_BASE_FREQ, 32'hffffff);
        write_reg(REG_PERSIST, 32'h1ffff);
        write_reg(REG_HEIGHT_GAIN, 32'h7fffffff);
        write_reg(REG_SEED, 32'h7fffffff);
        drain_results();
        for (int k = 0; k < 6; k++) send_point(edge_vals[k], edge_vals[5 - k], 1'b0);
        sample_ch.valid <= 1'b0;
        drain_results();
        write_reg(REG_PERSIST, 32'd0);
        write_reg(REG_HEIGHT_GAIN, 32'd0);
        write_reg(REG_OCT_COUNT, 32'd8);
        send_point(32'h00018000, 32'hfffe8000, 1'b0);
        sample_ch.valid <= 1'b0;
        drain_results();

        // Random phases over several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_BASE_FREQ, ph == 0 ? 32'd1 : 32'($urandom_range(24'hffffff, 1)));
            write_reg(REG_PERSIST, ph == 1 ? 32'd65536 : 32'($urandom_range(17'h1ffff)));
            write_reg(REG_HEIGHT_GAIN, (ph % 2) ? 32'($urandom) & 32'h7fffffff
                                                : 32'($urandom_range(200000)));
            write_reg(REG_OCT_COUNT, 32'($urandom_range(15)));
            write_reg(REG_SEED, $urandom);
            if (ph == 2) begin
                // Long receiver hold-off while points keep coming.
                sink_hold = 200;
                random_points(120, 1'b0);
            end else if (ph == 3) begin
                idle_sink = 1'b0;
                random_points(120, 1'b0);
                @(posedge i_clk);
                idle_sink = 1'b1;
            end else begin
                random_points(120, 1'b1);
            end
            drain_results();
        end

        $display("covered %0d points over %0d heights; extremes, all registers, stalls",
                 sent_points, board.checked);
        $display("leftover predictions: %0d", board.pending.size());
        if (board.pending.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire
